// File: design/wmti_pkg.sv
// Shared types, widths and constant tables for the web Mercator tile index core.
// Depends on nothing; every other design file but wmti_if refers to it by scoped names.
package wmti_pkg;

  // Saturation decision for one tile index.
  typedef enum logic [1:0] {
    SAT_NONE = 2'd0,
    SAT_LOW  = 2'd1,
    SAT_HIGH = 2'd2
  } sat_t;

  // Control that travels with every item through the pipeline.
  typedef struct packed {
    logic [4:0] zoom;
    sat_t       col_sat;
    sat_t       row_sat;
  } ctrl_t;

  localparam int CORDIC_STEPS = 40;
  localparam int LOG_STEPS    = 32;
  localparam int XW           = 43;  // CORDIC x, y and angle width, signed
  localparam int UW           = 42;  // positive CORDIC output as unsigned
  localparam int PW           = 6;   // bit position of the leading one
  localparam int MW           = 32;  // log mantissa and fraction width

  // Restoring division, used only while elaborating the constants below.
  function automatic logic [63:0] udiv(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], a[i]};
      q = {q[62:0], 1'b0};
      if (r >= b) begin
        r    = r - b;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // Arctangent of 2^-i in Q62 by its power series.
  function automatic logic [63:0] atan_pow2_q62(input int i);
    logic [63:0] sum;
    logic [63:0] t;
    int          e;
    sum = '0;
    e   = 62 - i;
    for (int k = 0; k < 64; k++) begin
      if (e >= 0) begin
        t = udiv(64'd1 << e, 64'(2 * k + 1));
        if ((k & 1) == 1) sum = sum - t;
        else sum = sum + t;
        e = e - 2 * i;
      end
    end
    return sum;
  endfunction

  // Arctangent of 1/3 in Q62.
  function automatic logic [63:0] atan_third_q62();
    logic [63:0] sum;
    logic [63:0] p;
    logic [63:0] t;
    sum = '0;
    p   = udiv(64'd1 << 62, 64'd3);
    for (int k = 0; k < 64; k++) begin
      if (p != 0) begin
        t = udiv(p, 64'(2 * k + 1));
        if ((k & 1) == 1) sum = sum - t;
        else sum = sum + t;
        p = udiv(p, 64'd9);
      end
    end
    return sum;
  endfunction

  // Natural log of two in Q62.
  function automatic logic [63:0] ln2_q62();
    logic [63:0] sum;
    sum = '0;
    for (int k = 1; k <= 62; k++) begin
      sum = sum + udiv(64'd1 << (62 - k), 64'(k));
    end
    return sum;
  endfunction

  // floor(a * 2^n / b) for a below b.
  function automatic logic [63:0] div_frac(input logic [63:0] a, input logic [63:0] b,
                                           input int n);
    logic [63:0] r;
    logic [63:0] q;
    r = a;
    q = '0;
    for (int i = 0; i < 64; i++) begin
      if (i < n) begin
        r = {r[62:0], 1'b0};
        q = {q[62:0], 1'b0};
        if (r >= b) begin
          r    = r - b;
          q[0] = 1'b1;
        end
      end
    end
    return q;
  endfunction

  localparam logic [63:0] QUARTER_PI = atan_pow2_q62(1) + atan_third_q62();
  localparam logic [63:0] FULL_PI    = {QUARTER_PI[61:0], 2'b00};
  localparam logic [63:0] ATAN0      = (QUARTER_PI + (64'd1 << 21)) >> 22;
  localparam logic [63:0] DEG_SCALE  = (udiv(FULL_PI, 64'd360) + (64'd1 << 23)) >> 24;
  localparam logic [63:0] LOG_SCALE  = div_frac(ln2_q62() >> 1, FULL_PI >> 1, 30);

  // CORDIC rotation angle of step i in Q40, rounded to nearest.
  function automatic logic [63:0] atan_q40(input int i);
    logic [63:0] v;
    if (i == 0) v = QUARTER_PI;
    else v = atan_pow2_q62(i);
    return (v + (64'd1 << 21)) >> 22;
  endfunction

endpackage

// File: design/wmti_if.sv
// Valid/ready channel interfaces for the coordinate input and the tile index result.
// Depends on nothing; the top level takes one of each.
interface wmti_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] latitude;
  logic signed [32:0] longitude;
  logic        [4:0]  zoom_level;

  modport source(output valid, latitude, longitude, zoom_level, input ready);
  modport sink(input valid, latitude, longitude, zoom_level, output ready);
endinterface

interface wmti_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] tile_column;
  logic [23:0] tile_row;
  logic        clamped;

  modport source(output valid, tile_column, tile_row, clamped, input ready);
  modport sink(input valid, tile_column, tile_row, clamped, output ready);
endinterface

// File: design/wmti_front.sv
// Front end: input register, longitude offset, latitude scaling and start angle.
// Three register stages. Depends on wmti_pkg.
module wmti_front #(
  parameter int ANGLE_FRAC_BITS = 24,
  parameter int MAX_ZOOM        = 24,
  parameter int VW              = 35,
  parameter int RW              = 33
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv,
  input  logic                           in_valid,
  input  logic signed [31:0]             lat,
  input  logic signed [32:0]             lon,
  input  logic        [4:0]              zoom,
  output logic                           vld_o,
  output wmti_pkg::ctrl_t                ctrl_o,
  output logic signed [wmti_pkg::XW-1:0] a_o,
  output logic        [RW-1:0]           r_o
);

  localparam int XW = wmti_pkg::XW;
  localparam int SH = ANGLE_FRAC_BITS - 24;
  localparam logic [63:0] HALF64 = 64'd180 << ANGLE_FRAC_BITS;
  localparam logic [63:0] FULL64 = 64'd360 << ANGLE_FRAC_BITS;
  localparam logic [63:0] POLE64 = 64'd90 << ANGLE_FRAC_BITS;
  localparam logic signed [XW-1:0] A0 = $signed(wmti_pkg::ATAN0[XW-1:0]);

  logic                  vld0_r, vld1_r, vld2_r;
  wmti_pkg::ctrl_t       ctrl0_nxt, ctrl0_r, ctrl1_r, ctrl2_r;
  logic signed [VW-1:0]  v_nxt;
  logic signed [VW-1:0]  lon_ext;
  logic        [RW-1:0]  r0_r, r1_r, r2_r;
  logic        [31:0]    m;
  logic        [30:0]    m24_nxt, m0_r;
  logic                  south0_r, south1_r;
  logic        [4:0]     z;
  logic                  pole;
  logic        [62:0]    prod_nxt, prod1_r;
  logic signed [XW-1:0]  a_nxt, a2_r;
  logic signed [XW-1:0]  delta;

  // Stage 0: offset the longitude and fold the latitude to its magnitude.
  assign lon_ext = VW'(lon);
  assign v_nxt   = lon_ext + $signed(HALF64[VW-1:0]);
  assign m       = lat[31] ? 32'(-lat) : 32'(lat);
  assign pole    = ({32'b0, m} >= POLE64);
  assign z       = (zoom > 5'(MAX_ZOOM)) ? 5'(MAX_ZOOM) : zoom;

  generate
    if (SH >= 0) begin : g_shr
      assign m24_nxt = 31'(m >> SH);
    end else begin : g_shl
      localparam int LS = -SH;
      assign m24_nxt = 31'({32'b0, m} << LS);
    end
  endgenerate

  always_comb begin
    ctrl0_nxt.zoom = z;
    if (v_nxt < 0) ctrl0_nxt.col_sat = wmti_pkg::SAT_LOW;
    else if (v_nxt >= $signed(FULL64[VW-1:0])) ctrl0_nxt.col_sat = wmti_pkg::SAT_HIGH;
    else ctrl0_nxt.col_sat = wmti_pkg::SAT_NONE;
    if (pole) ctrl0_nxt.row_sat = lat[31] ? wmti_pkg::SAT_HIGH : wmti_pkg::SAT_LOW;
    else ctrl0_nxt.row_sat = wmti_pkg::SAT_NONE;
  end

  // Stage 1: degrees to radians.
  assign prod_nxt = m0_r * wmti_pkg::DEG_SCALE[31:0];

  // Stage 2: start angle an eighth of a turn plus or minus the scaled latitude.
  assign delta = $signed({2'b00, prod1_r[62:22]});
  assign a_nxt = south1_r ? (A0 - delta) : (A0 + delta);

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (adv) begin
      vld0_r <= in_valid;
      vld1_r <= vld0_r;
      vld2_r <= vld1_r;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (adv) begin
      ctrl0_r  <= ctrl0_nxt;
      r0_r     <= v_nxt[RW-1:0];
      m0_r     <= m24_nxt;
      south0_r <= lat[31];
      ctrl1_r  <= ctrl0_r;
      r1_r     <= r0_r;
      prod1_r  <= prod_nxt;
      south1_r <= south0_r;
      ctrl2_r  <= ctrl1_r;
      r2_r     <= r1_r;
      a2_r     <= a_nxt;
    end
  end

  assign vld_o  = vld2_r;
  assign ctrl_o = ctrl2_r;
  assign a_o    = a2_r;
  assign r_o    = r2_r;

endmodule

// File: design/wmti_cordic_stage.sv
// One CORDIC rotation step, plus one restoring step of the column division while IDX < QW.
// One register stage. Depends on wmti_pkg.
module wmti_cordic_stage #(
  parameter int          IDX     = 0,
  parameter int          RW      = 33,
  parameter int          QW      = 24,
  parameter logic [63:0] DIVISOR = 64'd1
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv,
  input  logic                           vld_i,
  input  wmti_pkg::ctrl_t                ctrl_i,
  input  logic signed [wmti_pkg::XW-1:0] x_i,
  input  logic signed [wmti_pkg::XW-1:0] y_i,
  input  logic signed [wmti_pkg::XW-1:0] a_i,
  input  logic        [RW-1:0]           r_i,
  input  logic        [QW-1:0]           q_i,
  output logic                           vld_o,
  output wmti_pkg::ctrl_t                ctrl_o,
  output logic signed [wmti_pkg::XW-1:0] x_o,
  output logic signed [wmti_pkg::XW-1:0] y_o,
  output logic signed [wmti_pkg::XW-1:0] a_o,
  output logic        [RW-1:0]           r_o,
  output logic        [QW-1:0]           q_o
);

  localparam int XW = wmti_pkg::XW;
  localparam logic [63:0] ATAN64 = wmti_pkg::atan_q40(IDX);
  localparam logic signed [XW-1:0] ATAN = $signed(ATAN64[XW-1:0]);

  logic                 vld_r;
  wmti_pkg::ctrl_t      ctrl_r;
  logic signed [XW-1:0] dx, dy;
  logic signed [XW-1:0] x_nxt, y_nxt, a_nxt, x_r, y_r, a_r;
  logic        [RW-1:0] r_nxt, r_r;
  logic        [QW-1:0] q_nxt, q_r;

  // Rotate toward zero residual angle; the shifts round toward minus infinity.
  assign dx = y_i >>> IDX;
  assign dy = x_i >>> IDX;

  always_comb begin
    if (!a_i[XW-1]) begin
      x_nxt = x_i - dx;
      y_nxt = y_i + dy;
      a_nxt = a_i - ATAN;
    end else begin
      x_nxt = x_i + dx;
      y_nxt = y_i - dy;
      a_nxt = a_i + ATAN;
    end
  end

  // Column quotient, one bit per stage while bits remain.
  generate
    if (IDX < QW) begin : g_div
      logic [RW:0] r2;
      logic [QW:0] q2;
      logic        bit_q;
      assign r2    = {r_i, 1'b0};
      assign bit_q = (r2 >= DIVISOR[RW:0]);
      assign q2    = {q_i, bit_q};
      assign q_nxt = q2[QW-1:0];
      assign r_nxt = bit_q ? RW'(r2 - DIVISOR[RW:0]) : r2[RW-1:0];
    end else begin : g_hold
      assign q_nxt = q_i;
      assign r_nxt = r_i;
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctrl_r <= ctrl_i;
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      a_r    <= a_nxt;
      r_r    <= r_nxt;
      q_r    <= q_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign ctrl_o = ctrl_r;
  assign x_o    = x_r;
  assign y_o    = y_r;
  assign a_o    = a_r;
  assign r_o    = r_r;
  assign q_o    = q_r;

endmodule

// File: design/wmti_norm.sv
// Near-pole checks, leading-one search and mantissa normalization for both log lanes.
// Two register stages. Depends on wmti_pkg.
module wmti_norm #(
  parameter int QW = 24
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv,
  input  logic                           vld_i,
  input  wmti_pkg::ctrl_t                ctrl_i,
  input  logic signed [wmti_pkg::XW-1:0] x_i,
  input  logic signed [wmti_pkg::XW-1:0] y_i,
  input  logic        [QW-1:0]           q_i,
  output logic                           vld_o,
  output wmti_pkg::ctrl_t                ctrl_o,
  output logic        [wmti_pkg::MW-1:0] mx_o,
  output logic        [wmti_pkg::MW-1:0] my_o,
  output logic        [wmti_pkg::PW-1:0] px_o,
  output logic        [wmti_pkg::PW-1:0] py_o,
  output logic        [QW-1:0]           q_o
);

  localparam int UW = wmti_pkg::UW;
  localparam int PW = wmti_pkg::PW;
  localparam int MW = wmti_pkg::MW;

  logic            vlda_r, vldb_r;
  wmti_pkg::ctrl_t ctrla_nxt, ctrla_r, ctrlb_r;
  logic [UW-1:0]   ux_r, uy_r;
  logic [PW-1:0]   px_nxt, py_nxt, pxa_r, pya_r, pxb_r, pyb_r;
  logic [MW-1:0]   mx_nxt, my_nxt, mx_r, my_r;
  logic [QW-1:0]   qa_r, qb_r;

  // Position of the most significant set bit, zero for zero.
  function automatic logic [PW-1:0] lead_pos(input logic [UW-1:0] u);
    logic [PW-1:0] p;
    p = '0;
    for (int i = 0; i < UW; i++) begin
      if (u[i]) p = PW'(i);
    end
    return p;
  endfunction

  // Bring the leading one to bit 31.
  function automatic logic [MW-1:0] norm_mant(input logic [UW-1:0] u, input logic [PW-1:0] p);
    logic [MW-1:0] m;
    if (p >= PW'(31)) m = MW'(u >> (p - PW'(31)));
    else m = MW'(u << (PW'(31) - p));
    return m;
  endfunction

  // Stage A: a rotation that leaves x or y non-positive saturates the row.
  always_comb begin
    ctrla_nxt = ctrl_i;
    if (ctrl_i.row_sat == wmti_pkg::SAT_NONE) begin
      if (x_i <= 0) ctrla_nxt.row_sat = wmti_pkg::SAT_LOW;
      else if (y_i <= 0) ctrla_nxt.row_sat = wmti_pkg::SAT_HIGH;
    end
  end

  assign px_nxt = lead_pos(x_i[UW-1:0]);
  assign py_nxt = lead_pos(y_i[UW-1:0]);

  // Stage B: normalized mantissas in Q31.
  assign mx_nxt = norm_mant(ux_r, pxa_r);
  assign my_nxt = norm_mant(uy_r, pya_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vlda_r <= 1'b0;
      vldb_r <= 1'b0;
    end else if (adv) begin
      vlda_r <= vld_i;
      vldb_r <= vlda_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctrla_r <= ctrla_nxt;
      ux_r    <= x_i[UW-1:0];
      uy_r    <= y_i[UW-1:0];
      pxa_r   <= px_nxt;
      pya_r   <= py_nxt;
      qa_r    <= q_i;
      ctrlb_r <= ctrla_r;
      mx_r    <= mx_nxt;
      my_r    <= my_nxt;
      pxb_r   <= pxa_r;
      pyb_r   <= pya_r;
      qb_r    <= qa_r;
    end
  end

  assign vld_o  = vldb_r;
  assign ctrl_o = ctrlb_r;
  assign mx_o   = mx_r;
  assign my_o   = my_r;
  assign px_o   = pxb_r;
  assign py_o   = pyb_r;
  assign q_o    = qb_r;

endmodule

// File: design/wmti_log_stage.sv
// One squaring step of the base-2 logarithm, for the x and the y lane side by side.
// One register stage. Depends on wmti_pkg.
module wmti_log_stage #(
  parameter int QW = 24
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv,
  input  logic                           vld_i,
  input  wmti_pkg::ctrl_t                ctrl_i,
  input  logic        [wmti_pkg::MW-1:0] mx_i,
  input  logic        [wmti_pkg::MW-1:0] my_i,
  input  logic        [wmti_pkg::MW-1:0] fx_i,
  input  logic        [wmti_pkg::MW-1:0] fy_i,
  input  logic        [wmti_pkg::PW-1:0] px_i,
  input  logic        [wmti_pkg::PW-1:0] py_i,
  input  logic        [QW-1:0]           q_i,
  output logic                           vld_o,
  output wmti_pkg::ctrl_t                ctrl_o,
  output logic        [wmti_pkg::MW-1:0] mx_o,
  output logic        [wmti_pkg::MW-1:0] my_o,
  output logic        [wmti_pkg::MW-1:0] fx_o,
  output logic        [wmti_pkg::MW-1:0] fy_o,
  output logic        [wmti_pkg::PW-1:0] px_o,
  output logic        [wmti_pkg::PW-1:0] py_o,
  output logic        [QW-1:0]           q_o
);

  localparam int MW = wmti_pkg::MW;
  localparam int PW = wmti_pkg::PW;

  logic            vld_r;
  wmti_pkg::ctrl_t ctrl_r;
  logic [2*MW-1:0] sqx, sqy;
  logic [MW:0]     tx, ty;
  logic [MW-1:0]   mx_nxt, my_nxt, fx_nxt, fy_nxt, mx_r, my_r, fx_r, fy_r;
  logic [PW-1:0]   px_r, py_r;
  logic [QW-1:0]   q_r;

  // Square the Q31 mantissa; a carry into bit 32 is the next fraction bit.
  assign sqx    = mx_i * mx_i;
  assign sqy    = my_i * my_i;
  assign tx     = sqx[2*MW-1:MW-1];
  assign ty     = sqy[2*MW-1:MW-1];
  assign mx_nxt = tx[MW] ? tx[MW:1] : tx[MW-1:0];
  assign my_nxt = ty[MW] ? ty[MW:1] : ty[MW-1:0];
  assign fx_nxt = {fx_i[MW-2:0], tx[MW]};
  assign fy_nxt = {fy_i[MW-2:0], ty[MW]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctrl_r <= ctrl_i;
      mx_r   <= mx_nxt;
      my_r   <= my_nxt;
      fx_r   <= fx_nxt;
      fy_r   <= fy_nxt;
      px_r   <= px_i;
      py_r   <= py_i;
      q_r    <= q_i;
    end
  end

  assign vld_o  = vld_r;
  assign ctrl_o = ctrl_r;
  assign mx_o   = mx_r;
  assign my_o   = my_r;
  assign fx_o   = fx_r;
  assign fy_o   = fy_r;
  assign px_o   = px_r;
  assign py_o   = py_r;
  assign q_o    = q_r;

endmodule

// File: design/wmti_back.sv
// Back end: log difference, scaling to the grid, row and column selection, output register.
// Four register stages. Depends on wmti_pkg.
module wmti_back #(
  parameter int MAX_ZOOM = 24
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv,
  input  logic                           vld_i,
  input  wmti_pkg::ctrl_t                ctrl_i,
  input  logic        [wmti_pkg::MW-1:0] fx_i,
  input  logic        [wmti_pkg::MW-1:0] fy_i,
  input  logic        [wmti_pkg::PW-1:0] px_i,
  input  logic        [wmti_pkg::PW-1:0] py_i,
  input  logic        [MAX_ZOOM-1:0]     q_i,
  output logic                           out_valid,
  output logic        [23:0]             tile_column,
  output logic        [23:0]             tile_row,
  output logic                           clamped
);

  localparam int QW = MAX_ZOOM;
  localparam int IW = MAX_ZOOM + 1;
  localparam int LW = wmti_pkg::PW + wmti_pkg::MW;
  localparam logic signed [LW:0] G_LIMIT = $signed((LW + 1)'(64'h5_0000_0000));
  localparam logic [63:0] TWO62 = 64'h4000_0000_0000_0000;

  logic                vldg_r, vldp_r, vldf_r, out_valid_r;
  wmti_pkg::ctrl_t     ctrlg_nxt, ctrlg_r, ctrlp_r, ctrlf_nxt, ctrlf_r;
  logic [QW-1:0]       qg_r, qp_r, qf_r;
  logic [LW-1:0]       lx, ly;
  logic signed [LW:0]  g;
  logic [LW:0]         gabs;
  logic [34:0]         mag_nxt, magg_r;
  logic                negg_r, negp_r;
  logic [63:0]         prod_nxt, prodp_r;
  logic [63:0]         f_nxt, ff_r;
  logic [5:0]          shamt;
  logic [IW-1:0]       rowv, last, colv, col_nxt, row_nxt, col_r, row_r;
  logic [63:0]         fsh;
  logic                over, clamp_nxt, clamp_r;
  logic [4:0]          z, z_r;
  logic [IW+23:0]      col_ext, row_ext;

  // Stage G: g = log2(y) - log2(x); beyond five octaves the row is off the grid.
  assign lx   = {px_i, fx_i};
  assign ly   = {py_i, fy_i};
  assign g    = $signed({1'b0, ly}) - $signed({1'b0, lx});
  assign gabs = g[LW] ? (LW + 1)'(-g) : g;
  assign mag_nxt = gabs[34:0];

  always_comb begin
    ctrlg_nxt = ctrl_i;
    if (ctrl_i.row_sat == wmti_pkg::SAT_NONE) begin
      if (g >= G_LIMIT) ctrlg_nxt.row_sat = wmti_pkg::SAT_LOW;
      else if (g <= -G_LIMIT) ctrlg_nxt.row_sat = wmti_pkg::SAT_HIGH;
    end
  end

  // Stage P: scale by ln2 / (2 pi), keeping the full product.
  assign prod_nxt = {29'b0, magg_r} * {34'b0, wmti_pkg::LOG_SCALE[29:0]};

  // Stage F: row position from the top edge, as a fraction of the grid in Q63.
  always_comb begin
    ctrlf_nxt = ctrlp_r;
    if (!negp_r) begin
      if ((prodp_r > TWO62) && (ctrlp_r.row_sat == wmti_pkg::SAT_NONE)) begin
        ctrlf_nxt.row_sat = wmti_pkg::SAT_LOW;
      end
      f_nxt = TWO62 - prodp_r;
    end else begin
      f_nxt = TWO62 + prodp_r;
    end
  end

  // Output stage: pick the indices at the item's zoom and saturate.
  assign z     = ctrlf_r.zoom;
  assign shamt = 6'd63 - 6'(z);
  assign fsh   = ff_r >> shamt;
  assign rowv  = fsh[IW-1:0];
  assign last  = (IW'(1) << z) - IW'(1);
  assign over  = ((rowv >> z) != '0);
  assign colv  = {1'b0, qf_r >> (6'(QW) - 6'(z))};

  always_comb begin
    case (ctrlf_r.col_sat)
      wmti_pkg::SAT_LOW:  col_nxt = '0;
      wmti_pkg::SAT_HIGH: col_nxt = last;
      default:            col_nxt = colv;
    endcase
    case (ctrlf_r.row_sat)
      wmti_pkg::SAT_LOW:  row_nxt = '0;
      wmti_pkg::SAT_HIGH: row_nxt = last;
      default:            row_nxt = over ? last : rowv;
    endcase
    clamp_nxt = (ctrlf_r.col_sat != wmti_pkg::SAT_NONE) ||
                (ctrlf_r.row_sat != wmti_pkg::SAT_NONE) || over;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vldg_r      <= 1'b0;
      vldp_r      <= 1'b0;
      vldf_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vldg_r      <= vld_i;
      vldp_r      <= vldg_r;
      vldf_r      <= vldp_r;
      out_valid_r <= vldf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctrlg_r <= ctrlg_nxt;
      qg_r    <= q_i;
      magg_r  <= mag_nxt;
      negg_r  <= g[LW];
      ctrlp_r <= ctrlg_r;
      qp_r    <= qg_r;
      prodp_r <= prod_nxt;
      negp_r  <= negg_r;
      ctrlf_r <= ctrlf_nxt;
      qf_r    <= qp_r;
      ff_r    <= f_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      clamp_r <= clamp_nxt;
      z_r     <= z;
    end
  end

  // The field is 24 bits wide whatever the grid size.
  assign col_ext     = {24'b0, col_r};
  assign row_ext     = {24'b0, row_r};
  assign out_valid   = out_valid_r;
  assign tile_column = col_ext[23:0];
  assign tile_row    = row_ext[23:0];
  assign clamped     = clamp_r;

`ifndef NO_ASSERTIONS
  // An unclamped result always lies on the grid.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !clamp_r |-> ((col_r >> z_r) == '0) && ((row_r >> z_r) == '0))
    else $error("unclamped tile index outside the grid");

  // A saturated column must raise the clamp flag.
  assert property (@(posedge clk) disable iff (!rst_n)
    adv && vldf_r && (ctrlf_r.col_sat != wmti_pkg::SAT_NONE) |=> clamp_r)
    else $error("column saturated without clamp");

  // A southern saturation lands on the last row.
  assert property (@(posedge clk) disable iff (!rst_n)
    adv && vldf_r && (ctrlf_r.row_sat == wmti_pkg::SAT_HIGH) |=>
      clamp_r && (row_r == ((IW'(1) << z_r) - IW'(1))))
    else $error("southern saturation not on last row");
`endif

endmodule

// File: design/web_mercator_tile_index_core.sv
// Web Mercator tile index core: latitude, longitude and zoom in, tile column and row out.
// Depends on wmti_pkg, wmti_if and the wmti_* stage modules.
//
// Takes one coordinate item per clock while the pipeline advances and returns one result
// per item, in order, through 3 front stages, 40 CORDIC stages (one rotation each, the
// column quotient computed one bit per stage in the first MAX_ZOOM of them), 2 normalize
// stages, 32 logarithm squaring stages and 4 back stages ending in the output register. The
// whole pipeline advances together; it freezes only while the output register holds a
// result that the sink does not take, so in_ready is low exactly then. Zoom above MAX_ZOOM
// is taken as MAX_ZOOM; indices that fall off the grid are saturated and flagged in clamped.
module web_mercator_tile_index_core #(
  parameter int MAX_ZOOM        = 24,
  parameter int ANGLE_FRAC_BITS = 24
) (
  input logic              clk,
  input logic              rst_n,
  wmti_in_if.sink          in_chan,
  wmti_out_if.source       out_chan
);

  localparam int XW = wmti_pkg::XW;
  localparam int MW = wmti_pkg::MW;
  localparam int PW = wmti_pkg::PW;
  localparam int NC = wmti_pkg::CORDIC_STEPS;
  localparam int NL = wmti_pkg::LOG_STEPS;
  localparam int QW = MAX_ZOOM;
  localparam int VW = ((ANGLE_FRAC_BITS + 8 > 33) ? ANGLE_FRAC_BITS + 8 : 33) + 2;
  localparam int RW = ANGLE_FRAC_BITS + 9;
  localparam logic [63:0] DIVISOR = 64'd360 << ANGLE_FRAC_BITS;

  logic adv;
  logic out_valid;

  logic                 cv [0:NC];
  wmti_pkg::ctrl_t      cc [0:NC];
  logic signed [XW-1:0] cx [0:NC];
  logic signed [XW-1:0] cy [0:NC];
  logic signed [XW-1:0] ca [0:NC];
  logic        [RW-1:0] cr [0:NC];
  logic        [QW-1:0] cq [0:NC];

  logic                 lv  [0:NL];
  wmti_pkg::ctrl_t      lc  [0:NL];
  logic        [MW-1:0] lmx [0:NL];
  logic        [MW-1:0] lmy [0:NL];
  logic        [MW-1:0] lfx [0:NL];
  logic        [MW-1:0] lfy [0:NL];
  logic        [PW-1:0] lpx [0:NL];
  logic        [PW-1:0] lpy [0:NL];
  logic        [QW-1:0] lq  [0:NL];

  // Every stage moves on when the output register is free or being taken.
  assign adv            = !out_valid || out_chan.ready;
  assign in_chan.ready  = adv;
  assign out_chan.valid = out_valid;

  wmti_front #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
    .MAX_ZOOM       (MAX_ZOOM),
    .VW             (VW),
    .RW             (RW)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_valid(in_chan.valid),
    .lat     (in_chan.latitude),
    .lon     (in_chan.longitude),
    .zoom    (in_chan.zoom_level),
    .vld_o   (cv[0]),
    .ctrl_o  (cc[0]),
    .a_o     (ca[0]),
    .r_o     (cr[0])
  );

  // The rotation starts from the unit vector on the x axis.
  assign cx[0] = $signed(XW'(64'd1 << 40));
  assign cy[0] = '0;
  assign cq[0] = '0;

  // CORDIC chain.
  generate
    for (genvar i = 0; i < NC; i++) begin : g_cordic
      wmti_cordic_stage #(
        .IDX    (i),
        .RW     (RW),
        .QW     (QW),
        .DIVISOR(DIVISOR)
      ) u_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .vld_i (cv[i]),
        .ctrl_i(cc[i]),
        .x_i   (cx[i]),
        .y_i   (cy[i]),
        .a_i   (ca[i]),
        .r_i   (cr[i]),
        .q_i   (cq[i]),
        .vld_o (cv[i+1]),
        .ctrl_o(cc[i+1]),
        .x_o   (cx[i+1]),
        .y_o   (cy[i+1]),
        .a_o   (ca[i+1]),
        .r_o   (cr[i+1]),
        .q_o   (cq[i+1])
      );
    end
  endgenerate

  wmti_norm #(
    .QW(QW)
  ) u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .vld_i (cv[NC]),
    .ctrl_i(cc[NC]),
    .x_i   (cx[NC]),
    .y_i   (cy[NC]),
    .q_i   (cq[NC]),
    .vld_o (lv[0]),
    .ctrl_o(lc[0]),
    .mx_o  (lmx[0]),
    .my_o  (lmy[0]),
    .px_o  (lpx[0]),
    .py_o  (lpy[0]),
    .q_o   (lq[0])
  );

  assign lfx[0] = '0;
  assign lfy[0] = '0;

  // Logarithm fraction chain, one bit per stage.
  generate
    for (genvar j = 0; j < NL; j++) begin : g_log
      wmti_log_stage #(
        .QW(QW)
      ) u_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .vld_i (lv[j]),
        .ctrl_i(lc[j]),
        .mx_i  (lmx[j]),
        .my_i  (lmy[j]),
        .fx_i  (lfx[j]),
        .fy_i  (lfy[j]),
        .px_i  (lpx[j]),
        .py_i  (lpy[j]),
        .q_i   (lq[j]),
        .vld_o (lv[j+1]),
        .ctrl_o(lc[j+1]),
        .mx_o  (lmx[j+1]),
        .my_o  (lmy[j+1]),
        .fx_o  (lfx[j+1]),
        .fy_o  (lfy[j+1]),
        .px_o  (lpx[j+1]),
        .py_o  (lpy[j+1]),
        .q_o   (lq[j+1])
      );
    end
  endgenerate

  wmti_back #(
    .MAX_ZOOM(MAX_ZOOM)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .vld_i      (lv[NL]),
    .ctrl_i     (lc[NL]),
    .fx_i       (lfx[NL]),
    .fy_i       (lfy[NL]),
    .px_i       (lpx[NL]),
    .py_i       (lpy[NL]),
    .q_i        (lq[NL]),
    .out_valid  (out_valid),
    .tile_column(out_chan.tile_column),
    .tile_row   (out_chan.tile_row),
    .clamped    (out_chan.clamped)
  );

endmodule

// File: verif/web_mercator_tile_index_core_tb.sv
// Self-checking testbench for web_mercator_tile_index_core: drives coordinate items, predicts
// tile column, row and clamp flag in a local fixed-point model, and checks every result.
// Depends on wmti_if and the design top level.
`timescale 1ns / 1ps

module web_mercator_tile_index_core_tb;

  typedef struct {
    logic signed [31:0] lat;
    logic signed [32:0] lon;
    logic        [4:0]  zoom;
  } coord_t;

  typedef struct {
    logic [23:0] col;
    logic [23:0] row;
    logic        clamp;
  } tile_t;

  localparam int ZOOM_CAP      = 24;
  localparam int ROT_STEPS     = 40;
  localparam int IDLE_LIMIT    = 3000;
  localparam int LONG_HOLD     = 400;
  localparam int PAUSE_AT_ITEM = 300;
  localparam int TAIL_CYCLES   = 120;

  logic clk;
  logic rst_n;

  wmti_in_if  in_chan ();
  wmti_out_if out_chan ();

  web_mercator_tile_index_core u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  // Derived fixed-point constants of the projection.
  longint unsigned rot_angle [ROT_STEPS];
  longint unsigned deg_to_rad;
  longint unsigned ln2_over_2pi;

  coord_t pending_coords[$];
  tile_t  expected_tiles[$];
  int     coords_sent;
  int     tiles_seen;
  int     errors;
  int     clamped_seen;
  int     idle_cycles;
  bit     paused_done;
  int     send_gap;
  int     recv_hold;
  bit     long_hold_done;

  // Arctangent of 2^-i in Q62 by its alternating series.
  function automatic longint unsigned series_atan_pow2(int i);
    longint unsigned acc;
    longint unsigned term;
    int              e;
    int              k;
    acc = 0;
    e   = 62 - i;
    k   = 0;
    while (e >= 0) begin
      term = (64'd1 << e) / (2 * k + 1);
      if (k % 2) acc = acc - term;
      else acc = acc + term;
      e = e - 2 * i;
      k++;
    end
    return acc;
  endfunction

  function automatic longint unsigned series_atan_third();
    longint unsigned acc;
    longint unsigned pw;
    longint unsigned term;
    int              k;
    acc = 0;
    pw  = (64'd1 << 62) / 3;
    k   = 0;
    while (pw != 0) begin
      term = pw / (2 * k + 1);
      if (k % 2) acc = acc - term;
      else acc = acc + term;
      pw = pw / 9;
      k++;
    end
    return acc;
  endfunction

  // floor(a * 2^n / b) by long division.
  function automatic longint unsigned frac_quotient(longint unsigned a, longint unsigned b,
                                                    int n);
    longint unsigned rem;
    longint unsigned quo;
    rem = a;
    quo = 0;
    for (int i = 0; i < n; i++) begin
      rem = rem << 1;
      quo = quo << 1;
      if (rem >= b) begin
        rem = rem - b;
        quo = quo | 1;
      end
    end
    return quo;
  endfunction

  task automatic build_projection_constants();
    longint unsigned qpi;
    longint unsigned fpi;
    longint unsigned ln2;
    qpi = series_atan_pow2(1) + series_atan_third();
    fpi = qpi * 4;
    rot_angle[0] = (qpi + (64'd1 << 21)) >> 22;
    for (int i = 1; i < ROT_STEPS; i++)
      rot_angle[i] = (series_atan_pow2(i) + (64'd1 << 21)) >> 22;
    deg_to_rad = (fpi / 360 + (64'd1 << 23)) >> 24;
    ln2 = 0;
    for (int k = 1; k <= 62; k++) ln2 = ln2 + (64'd1 << (62 - k)) / k;
    ln2_over_2pi = frac_quotient(ln2 >> 1, fpi >> 1, 30);
  endtask

  // Base-2 logarithm in Q32 by repeated squaring of the mantissa.
  function automatic longint unsigned log2_fixed(longint unsigned u);
    int              msb;
    longint unsigned man;
    longint unsigned fr;
    msb = 63;
    while (u[msb] == 1'b0 && msb > 0) msb--;
    man = (msb >= 31) ? (u >> (msb - 31)) : (u << (31 - msb));
    fr  = 0;
    for (int i = 0; i < 32; i++) begin
      man = (man * man) >> 31;
      fr  = fr << 1;
      if (man >= (64'd1 << 32)) begin
        man = man >> 1;
        fr  = fr | 1;
      end
    end
    return (longint'(msb) << 32) | fr;
  endfunction

  function automatic tile_t predict_tile(coord_t c);
    tile_t           t;
    int              z;
    longint          lon;
    longint          lat;
    longint          v;
    longint          width;
    longint unsigned last;
    longint unsigned mag;
    longint unsigned delta;
    longint unsigned prod;
    longint unsigned f;
    longint unsigned row;
    longint          x;
    longint          y;
    longint          ang;
    longint          dx;
    longint          dy;
    longint          g;
    bit              south;
    bit              row_done;
    z       = (c.zoom > ZOOM_CAP) ? ZOOM_CAP : c.zoom;
    t.clamp = 1'b0;
    last    = (64'd1 << z) - 1;

    // Column: exact quotient, saturated at both edges.
    lon   = c.lon;
    width = longint'(360) << 24;
    v     = lon + (longint'(180) << 24);
    if (v < 0) begin
      t.clamp = 1'b1;
      t.col   = '0;
    end else if (v >= width) begin
      t.clamp = 1'b1;
      t.col   = last[23:0];
    end else begin
      t.col = 24'(frac_quotient(v, width, z));
    end

    // Row: CORDIC tangent, log ratio, scaled into the grid.
    lat      = c.lat;
    south    = lat < 0;
    mag      = south ? -lat : lat;
    row_done = 1'b0;
    row      = 0;
    if (mag >= (64'd90 << 24)) begin
      t.clamp  = 1'b1;
      row      = south ? last : 0;
      row_done = 1'b1;
    end
    if (!row_done) begin
      delta = (mag * deg_to_rad) >> 22;
      ang   = south ? longint'(rot_angle[0]) - longint'(delta)
                    : longint'(rot_angle[0]) + longint'(delta);
      x = longint'(1) << 40;
      y = 0;
      for (int i = 0; i < ROT_STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (ang >= 0) begin
          x   = x - dx;
          y   = y + dy;
          ang = ang - longint'(rot_angle[i]);
        end else begin
          x   = x + dx;
          y   = y - dy;
          ang = ang + longint'(rot_angle[i]);
        end
      end
      if (x <= 0) begin
        t.clamp = 1'b1; row = 0; row_done = 1'b1;
      end else if (y <= 0) begin
        t.clamp = 1'b1; row = last; row_done = 1'b1;
      end
    end
    if (!row_done) begin
      g = longint'(log2_fixed(y)) - longint'(log2_fixed(x));
      if (g >= (longint'(5) << 32)) begin
        t.clamp = 1'b1; row = 0; row_done = 1'b1;
      end else if (g <= -(longint'(5) << 32)) begin
        t.clamp = 1'b1; row = last; row_done = 1'b1;
      end
    end
    if (!row_done) begin
      prod = ((g >= 0) ? g : -g) * ln2_over_2pi;
      if (g >= 0 && prod > (64'd1 << 62)) begin
        t.clamp = 1'b1; row = 0; row_done = 1'b1;
      end else begin
        f   = (g >= 0) ? (64'd1 << 62) - prod : (64'd1 << 62) + prod;
        row = f >> (63 - z);
        if (row > last) begin
          t.clamp = 1'b1;
          row     = last;
        end
      end
    end
    t.row = row[23:0];
    return t;
  endfunction

  function automatic void queue_coord(longint lat, longint lon, int zoom);
    coord_t c;
    c.lat  = lat[31:0];
    c.lon  = lon[32:0];
    c.zoom = zoom[4:0];
    pending_coords.push_back(c);
  endfunction

  // Clock generation.
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Input driver: presents pending items with random gaps, but none from item 420 to 520.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      send_gap      <= 0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        expected_tiles.push_back(predict_tile('{in_chan.latitude, in_chan.longitude,
                                                in_chan.zoom_level}));
        coords_sent++;
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (send_gap > 0) begin
          send_gap      <= send_gap - 1;
          in_chan.valid <= 1'b0;
        end else if (coords_sent == PAUSE_AT_ITEM && !paused_done) begin
          // Hold the sender until the pipeline has drained completely.
          in_chan.valid <= 1'b0;
          if (expected_tiles.size() == 0) paused_done <= 1'b1;
        end else if (pending_coords.size() > 0) begin
          coord_t c;
          c = pending_coords.pop_front();
          in_chan.valid      <= 1'b1;
          in_chan.latitude   <= c.lat;
          in_chan.longitude  <= c.lon;
          in_chan.zoom_level <= c.zoom;
          if (coords_sent >= 420 && coords_sent < 520) send_gap <= 0;
          else if ($urandom_range(0, 2) == 0) send_gap <= 0;
          else send_gap <= $urandom_range(0, 18);
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each transfer with the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      recv_hold      <= 0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        tiles_seen++;
        if (expected_tiles.size() == 0) begin
          $display("%0t: unexpected result col=%0d row=%0d clamped=%0b", $time,
                   out_chan.tile_column, out_chan.tile_row, out_chan.clamped);
          errors++;
        end else begin
          tile_t e;
          e = expected_tiles.pop_front();
          if (e.clamp) clamped_seen++;
          if (out_chan.tile_column !== e.col) begin
            $display("%0t: tile_column expected %0d actual %0d", $time, e.col,
                     out_chan.tile_column);
            errors++;
          end
          if (out_chan.tile_row !== e.row) begin
            $display("%0t: tile_row expected %0d actual %0d", $time, e.row,
                     out_chan.tile_row);
            errors++;
          end
          if (out_chan.clamped !== e.clamp) begin
            $display("%0t: clamped expected %0b actual %0b", $time, e.clamp,
                     out_chan.clamped);
            errors++;
          end
        end
        if (tiles_seen == 150 && !long_hold_done) begin
          long_hold_done <= 1'b1;
          recv_hold      <= LONG_HOLD;
          out_chan.ready <= 1'b0;
        end else if (tiles_seen >= 420 && tiles_seen < 520) begin
          out_chan.ready <= 1'b1;
        end else begin
          int w;
          w = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
          recv_hold      <= w;
          out_chan.ready <= (w == 0);
        end
      end else if (recv_hold > 0) begin
        recv_hold      <= recv_hold - 1;
        out_chan.ready <= (recv_hold == 1);
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      idle_cycles <= 0;
    else if (rst_n) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: timeout, %0d results still outstanding", $time,
                 expected_tiles.size());
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    longint r_lat;
    longint r_lon;
    int     r_zoom;
    int     mode;
    rst_n               = 1'b0;
    in_chan.valid       = 1'b0;
    in_chan.latitude    = '0;
    in_chan.longitude   = '0;
    in_chan.zoom_level  = '0;
    out_chan.ready      = 1'b0;
    coords_sent         = 0;
    tiles_seen          = 0;
    errors              = 0;
    clamped_seen        = 0;
    idle_cycles         = 0;
    paused_done         = 1'b0;
    long_hold_done      = 1'b0;
    build_projection_constants();

    // Directed: grid edges, poles, antimeridian, zoom extremes and the zoom cap.
    queue_coord(0, 0, 0);
    queue_coord(0, 0, 24);
    queue_coord(longint'(90) << 24, 0, 10);
    queue_coord(-(longint'(90) << 24), 0, 10);
    queue_coord((longint'(90) << 24) - 1, 0, 24);
    queue_coord(-(longint'(90) << 24) + 1, 0, 24);
    queue_coord(longint'(2147483647), 0, 5);
    queue_coord(-longint'(2147483648), 0, 5);
    queue_coord(0, longint'(180) << 24, 8);
    queue_coord(0, -(longint'(180) << 24), 8);
    queue_coord(0, (longint'(180) << 24) - 1, 24);
    queue_coord(0, -(longint'(180) << 24) - 1, 24);
    queue_coord(0, (longint'(1) << 32) - 1, 3);
    queue_coord(0, -(longint'(1) << 32), 3);
    queue_coord(longint'(1427163203), longint'(-1234567890), 31);
    queue_coord(longint'(-1427163203), longint'(1234567890), 25);
    queue_coord(longint'(1500000000), 12345, 24);
    queue_coord(longint'(-1500000000), -12345, 24);
    queue_coord(1, 1, 1);
    queue_coord(-1, -1, 1);
    queue_coord(longint'(85) << 24, longint'(90) << 24, 20);
    queue_coord(-(longint'(85) << 24), -(longint'(90) << 24), 20);

    // Random: mostly on-globe points, some near the poles, some raw field noise.
    for (int n = 0; n < 650; n++) begin
      mode = $urandom_range(0, 9);
      if (mode == 0) begin
        r_lat = longint'(signed'($urandom));
        r_lon = longint'({$urandom, $urandom}) & ((longint'(1) << 33) - 1);
        if (r_lon[32]) r_lon = r_lon - (longint'(1) << 33);
      end else begin
        if (mode == 1) begin
          r_lat = (longint'(90) << 24) - $urandom_range(0, 1 << 25);
          if ($urandom_range(0, 1)) r_lat = -r_lat;
        end else begin
          r_lat = longint'($urandom_range(0, 32'd3019898880)) - (longint'(90) << 24);
        end
        r_lon = longint'(64'({$urandom, $urandom}) % 64'd6039797761)
                - (longint'(180) << 24);
      end
      r_zoom = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 31) : $urandom_range(0, 24);
      queue_coord(r_lat, r_lon, r_zoom);
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_coords.size() == 0);
    @(posedge clk);
    while (in_chan.valid || expected_tiles.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d coordinate items and checked %0d results, %0d of them clamped.",
             coords_sent, tiles_seen, clamped_seen);
    $display("Covered poles, antimeridian, zoom cap, long output stall and full drain.");
    if (errors == 0 && expected_tiles.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
